// ===== src/sem_pkg.sv =====
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int POS_W  = 11;
  localparam int GRAD_W = 10;
  localparam int SUM_W  = 2 * GRAD_W + 1;
  localparam int ROOT_W = 8;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int WSIZE_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int HSIZE_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int REG_IDX_W = 1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [GRAD_W-1:0] ux;
    logic [GRAD_W-1:0] uy;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              frame_end;
  } grad_t;

endpackage

// ===== src/sem_ram.sv =====
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sem_fifo.sv =====
`timescale 1ns / 1ps
module sem_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sem_pkg::grad_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output sem_pkg::grad_t pop_data_o
);
  import sem_pkg::*;

  grad_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

// ===== src/sem_front.sv =====
`timescale 1ns / 1ps
module sem_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [sem_pkg::PIX_W-1:0]     pix_i,
  input  logic                          frame_start_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output sem_pkg::grad_t                push_data_o
);
  import sem_pkg::*;

  typedef enum logic [1:0] {
    FR_ACCEPT = 2'b01,
    FR_CALC   = 2'b10
  } fr_state_e;

  fr_state_e          state_q, state_d;
  logic [CFG_W-1:0]   frame_width_q, frame_height_q;
  logic [COL_W-1:0]   col_q, col_d, eff_col;
  logic [ROW_W-1:0]   row_q, row_d, eff_row;
  logic [PIX_W-1:0]   win_q [6];
  logic [PIX_W-1:0]   px_q;
  logic [PIX_W-1:0]   top, mid;
  logic [WSIZE_W-1:0] width_use, fw_ext;
  logic [HSIZE_W-1:0] height_use, fh_ext;
  logic               last_col, last_row, produced, accept, leave;
  logic signed [GRAD_W:0] gx, gy;
  logic signed [GRAD_W:0] at, am, au, bt, bu, ct, cm, cu;

  assign accept      = pix_valid_i && pix_ready_o;
  assign pix_ready_o = (state_q == FR_ACCEPT);
  assign eff_col     = frame_start_i ? '0 : col_q;
  assign eff_row     = frame_start_i ? '0 : row_q;

  always_comb begin
    fw_ext = WSIZE_W'(frame_width_q);
    fh_ext = HSIZE_W'(frame_height_q);
    if (fw_ext < WSIZE_W'(3)) begin
      width_use = WSIZE_W'(3);
    end else if (fw_ext > WSIZE_W'(MAX_WIDTH)) begin
      width_use = WSIZE_W'(MAX_WIDTH);
    end else begin
      width_use = fw_ext;
    end
    if (fh_ext < HSIZE_W'(3)) begin
      height_use = HSIZE_W'(3);
    end else if (fh_ext > HSIZE_W'(MAX_HEIGHT)) begin
      height_use = HSIZE_W'(MAX_HEIGHT);
    end else begin
      height_use = fh_ext;
    end
  end

  assign last_col = (WSIZE_W'(col_q) + 1'b1) >= width_use;
  assign last_row = (HSIZE_W'(row_q) + 1'b1) >= height_use;
  assign produced = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
  assign leave    = (state_q == FR_CALC) && (!produced || push_ready_i);

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (leave),
    .waddr_i (col_q),
    .wdata_i (mid),
    .re_i    (accept),
    .raddr_i (eff_col),
    .rdata_o (top)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (leave),
    .waddr_i (col_q),
    .wdata_i (px_q),
    .re_i    (accept),
    .raddr_i (eff_col),
    .rdata_o (mid)
  );

  always_comb begin
    at = (GRAD_W + 1)'(win_q[0]);
    am = (GRAD_W + 1)'(win_q[1]);
    au = (GRAD_W + 1)'(win_q[2]);
    bt = (GRAD_W + 1)'(win_q[3]);
    bu = (GRAD_W + 1)'(win_q[5]);
    ct = (GRAD_W + 1)'(top);
    cm = (GRAD_W + 1)'(mid);
    cu = (GRAD_W + 1)'(px_q);
    gx = (ct + (cm <<< 1) + cu) - (at + (am <<< 1) + au);
    gy = (au + (bu <<< 1) + cu) - (at + (bt <<< 1) + ct);
  end

  always_comb begin
    push_data_o.ux        = gx[GRAD_W] ? GRAD_W'(-gx) : GRAD_W'(gx);
    push_data_o.uy        = gy[GRAD_W] ? GRAD_W'(-gy) : GRAD_W'(gy);
    push_data_o.row       = POS_W'(row_q - 1'b1);
    push_data_o.col       = POS_W'(col_q - 1'b1);
    push_data_o.frame_end = last_col && last_row;
  end

  assign push_valid_o = (state_q == FR_CALC) && produced;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    unique case (state_q)
      FR_ACCEPT: begin
        if (accept) begin
          col_d   = eff_col;
          row_d   = eff_row;
          state_d = FR_CALC;
        end
      end
      FR_CALC: begin
        if (leave) begin
          state_d = FR_ACCEPT;
          if (last_col) begin
            col_d = '0;
            row_d = last_row ? '0 : row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = FR_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= FR_ACCEPT;
      col_q          <= '0;
      row_q          <= '0;
      frame_width_q  <= FRAME_WIDTH_RESET;
      frame_height_q <= FRAME_HEIGHT_RESET;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (leave) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pix_i;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FR_CALC))
    else $error("accepted pixel did not enter the calculation step");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && !push_ready_i) |=> (state_q == FR_CALC && $stable(col_q)
      && $stable(row_q)))
    else $error("pixel position moved while the queue was full");
`endif

endmodule

// ===== src/sem_back.sv =====
`timescale 1ns / 1ps
module sem_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_o,
  input  sem_pkg::grad_t            pop_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sem_pkg::ROOT_W-1:0] edge_value_o,
  output logic [sem_pkg::POS_W-1:0]  out_row_o,
  output logic [sem_pkg::POS_W-1:0]  out_col_o,
  output logic                      frame_end_o
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    BK_IDLE   = 5'b00001,
    BK_SQUARE = 5'b00010,
    BK_SUM    = 5'b00100,
    BK_ROOT   = 5'b01000,
    BK_DONE   = 5'b10000
  } bk_state_e;

  bk_state_e            state_q, state_d;
  grad_t                ent_q;
  logic [2*GRAD_W-1:0]  sqx_q, sqy_q;
  logic [SUM_W-1:0]     sum_q;
  logic [ROOT_W-1:0]    root_q, bit_q, trial;
  logic [2*ROOT_W-1:0]  trial_sq;
  logic                 out_valid_q, load;
  logic [ROOT_W-1:0]    edge_q;
  logic [POS_W-1:0]     row_q, col_q;
  logic                 fend_q;

  assign pop_o    = (state_q == BK_IDLE) && pop_valid_i;
  assign trial    = root_q | bit_q;
  assign trial_sq = trial * trial;
  assign load     = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (pop_valid_i) state_d = BK_SQUARE;
      BK_SQUARE: state_d = BK_SUM;
      BK_SUM:    state_d = BK_ROOT;
      BK_ROOT:   if (bit_q[0]) state_d = BK_DONE;
      BK_DONE:   if (load) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_SUM) begin
        bit_q <= {1'b1, {(ROOT_W - 1){1'b0}}};
      end else if (state_q == BK_ROOT) begin
        bit_q <= bit_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= pop_data_i;
    end
    if (state_q == BK_SQUARE) begin
      sqx_q <= ent_q.ux * ent_q.ux;
      sqy_q <= ent_q.uy * ent_q.uy;
    end
    if (state_q == BK_SUM) begin
      sum_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
      root_q <= '0;
    end
    if (state_q == BK_ROOT) begin
      if (SUM_W'(trial_sq) <= sum_q) begin
        root_q <= trial;
      end
    end
    if (load) begin
      edge_q <= root_q;
      row_q  <= ent_q.row;
      col_q  <= ent_q.col;
      fend_q <= ent_q.frame_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign frame_end_o  = fend_q;

`ifndef ASSERT_OFF
  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ROOT) |-> $onehot(bit_q))
    else $error("root trial bit is not one-hot");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> pop_valid_i)
    else $error("pop from an empty queue");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && state_q == BK_IDLE))
    else $error("finished result was not presented");
`endif

endmodule

// ===== src/sobel_edge_magnitude.sv =====
`timescale 1ns / 1ps
// Sobel edge magnitude over a raster stream of 8-bit gray pixels.
// Pixels enter on the s_axis channel, one transfer per pixel, with tuser
// high on the first pixel of a frame. Frame size is written through the
// cfg port (index 0 width, index 1 height) while the block is idle; the user
// must keep to this, as the block does not enforce it. For each interior
// pixel one result leaves on m_axis: the magnitude, its row and column, and
// tlast on the last interior result of the frame. The result for (r-1,c-1)
// follows the transfer of pixel (r,c). A new pixel is taken only after the
// previous one has left the calculation step, a wait set by the registered
// line store read and the window update that follows it. The back end takes
// one result at a time through its square, sum, 8-step bit-wise square root
// and done states, so once the 2-entry queue fills, interior pixels are taken
// only as results leave the back end. Reset clears the counters, the window
// and the queue and loads width 640 and height 480; the line stores are not
// cleared and need no sweep. When the receiver stalls, the result holds in
// the output register, the back end and then the queue fill, and s_axis_tready drops.
module sobel_edge_magnitude (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // pixel
  input  logic                          s_axis_tuser,  // frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // edge_value, out_row, out_col
  output logic                          m_axis_tlast   // frame_end
);
  import sem_pkg::*;

  logic              push_valid, push_ready, pop_valid, pop;
  grad_t             push_data, pop_data;
  logic [ROOT_W-1:0] edge_value;
  logic [POS_W-1:0]  out_row, out_col;

  sem_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_valid_i   (s_axis_tvalid),
    .pix_ready_o   (s_axis_tready),
    .pix_i         (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  sem_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .edge_value_o (edge_value),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .frame_end_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_col, out_row, edge_value};

endmodule
